[rtl/stes_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stes_pkg
// Shared types and constants of the sample-to-timestamp event stamper.
// ----------------------------------------------------------------------------
package stes_pkg;

  // default width of the absolute stamp
  localparam int unsigned STAMP_BITS_DEF = 32;

  // register reset values
  localparam logic [15:0] SPU_RESET = 16'd5;
  localparam logic [15:0] KAL_RESET = 16'd60000;

  // field widths
  localparam int unsigned DIV_BITS  = 16;
  localparam int unsigned RES_BITS  = 32;
  localparam int unsigned OUT_BITS  = 32;
  localparam int unsigned CNT_BITS  = 5;

  // configuration register indexes
  localparam logic CFG_SPU = 1'b0;
  localparam logic CFG_KAL = 1'b1;

  // request kinds
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_FIRST   = 2'd1,
    REQ_FURTHER = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_e;

  // result kinds
  localparam logic KIND_ACTION    = 1'b0;
  localparam logic KIND_KEEPALIVE = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

[rtl/sample_to_timestamp_event_stamper_unit.sv]
`default_nettype none
// A first action or a keep-alive tick runs through the bit-serial restoring
// divider, a step that folds in the quotient and the load of the output
// register; a further action goes straight to the output register load.
// Requests are taken only while idle, so none before the last is loaded.
// Reset: asynchronous, clears stamp, residue and quiet count; the configuration
// registers return to 5 samples per unit and a keep-alive limit of 60000.
// ----------------------------------------------------------------------------
// sample_to_timestamp_event_stamper_unit
// Turns elapsed audio samples into timestamp units and stamps outgoing events.
// ----------------------------------------------------------------------------
module sample_to_timestamp_event_stamper_unit
  import stes_pkg::*;
#(
  parameter int unsigned StampBits = STAMP_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_addr_i,
  input  wire logic [15:0]  cfg_data_i,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // elapsed samples, channel, action code, action value
  input  wire logic [55:0]  s_axis_tdata,
  // req_type
  input  wire logic [1:0]   s_axis_tuser,
  // output stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // absolute_stamp, delta_stamp, out_channel, out_action, out_value
  output logic [103:0]      m_axis_tdata,
  // out_kind
  output logic              m_axis_tuser
);

  localparam int unsigned ExtBits   = (StampBits > OUT_BITS) ? StampBits : OUT_BITS;
  localparam int unsigned DeltaBits = (StampBits < OUT_BITS) ? StampBits : OUT_BITS;

  state_e                 state_q, state_d;
  logic [15:0]            spu_q, kal_q;
  logic [StampBits-1:0]   stamp_q, stamp_d;
  logic [RES_BITS-1:0]    residue_q, residue_d;
  logic [15:0]            quiet_q, quiet_d;
  logic                   ka_q, ka_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic [RES_BITS-1:0]    dvd_q, dvd_d;
  logic [DIV_BITS:0]      rem_q, rem_d;

  // staged result
  logic                   stg_kind_q, stg_kind_d;
  logic [OUT_BITS-1:0]    stg_abs_q, stg_abs_d;
  logic [OUT_BITS-1:0]    stg_delta_q, stg_delta_d;
  logic [15:0]            stg_ch_q, stg_ch_d;
  logic [7:0]             stg_act_q, stg_act_d;
  logic [15:0]            stg_val_q, stg_val_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [103:0]           out_data_q, out_data_d;
  logic                   out_kind_q, out_kind_d;

  logic [DIV_BITS-1:0]    div_w;
  logic [DIV_BITS:0]      trial;
  logic                   ge;
  logic [StampBits-1:0]   sum_stamp;
  logic [ExtBits-1:0]     stamp_ext;
  logic [ExtBits-1:0]     sum_ext;
  logic [15:0]            quiet_inc;
  logic                   in_xfer;
  logic                   out_free;
  req_e                   req;
  logic [15:0]            in_elapsed;

  assign req        = req_e'(s_axis_tuser);
  assign in_elapsed = s_axis_tdata[15:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;

  // a zero divisor acts as one
  assign div_w = (spu_q == '0) ? DIV_BITS'(1) : spu_q;

  // one restoring division step
  assign trial = {rem_q[DIV_BITS-1:0], dvd_q[RES_BITS-1]};
  assign ge    = (trial >= {1'b0, div_w});

  // quotient folded into the stamp
  assign sum_stamp = stamp_q + StampBits'(dvd_q);
  assign stamp_ext = ExtBits'(stamp_q);
  assign sum_ext   = ExtBits'(sum_stamp);
  assign quiet_inc = quiet_q + 16'd1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spu_q <= SPU_RESET;
      kal_q <= KAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_SPU: spu_q <= cfg_data_i;
        CFG_KAL: kal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stamp_q     <= '0;
      residue_q   <= '0;
      quiet_q     <= '0;
      ka_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stamp_q     <= stamp_d;
      residue_q   <= residue_d;
      quiet_q     <= quiet_d;
      ka_q        <= ka_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    stg_kind_q  <= stg_kind_d;
    stg_abs_q   <= stg_abs_d;
    stg_delta_q <= stg_delta_d;
    stg_ch_q    <= stg_ch_d;
    stg_act_q   <= stg_act_d;
    stg_val_q   <= stg_val_d;
    out_data_q  <= out_data_d;
    out_kind_q  <= out_kind_d;
  end

  // sequencer: next state and datapath
  always_comb begin
    state_d     = state_q;
    stamp_d     = stamp_q;
    residue_d   = residue_q;
    quiet_d     = quiet_q;
    ka_d        = ka_q;
    cnt_d       = cnt_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    stg_kind_d  = stg_kind_q;
    stg_abs_d   = stg_abs_q;
    stg_delta_d = stg_delta_q;
    stg_ch_d    = stg_ch_q;
    stg_act_d   = stg_act_q;
    stg_val_d   = stg_val_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          stg_ch_d   = s_axis_tdata[31:16];
          stg_act_d  = s_axis_tdata[39:32];
          stg_val_d  = s_axis_tdata[55:40];
          stg_kind_d = KIND_ACTION;
          cnt_d      = '0;
          rem_d      = '0;
          dvd_d      = residue_q + RES_BITS'(in_elapsed);
          case (req)
            REQ_FIRST: begin
              residue_d = residue_q + RES_BITS'(in_elapsed);
              quiet_d   = '0;
              ka_d      = 1'b0;
              state_d   = ST_DIV;
            end
            REQ_FURTHER: begin
              quiet_d     = '0;
              stg_abs_d   = stamp_ext[OUT_BITS-1:0];
              stg_delta_d = '0;
              state_d     = ST_EMIT;
            end
            REQ_TICK: begin
              residue_d = residue_q + RES_BITS'(in_elapsed);
              if (quiet_inc == kal_q) begin
                quiet_d = '0;
                ka_d    = 1'b1;
                state_d = ST_DIV;
              end else begin
                quiet_d = quiet_inc;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        rem_d = ge ? (trial - {1'b0, div_w}) : trial;
        dvd_d = {dvd_q[RES_BITS-2:0], ge};
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == '1) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        stg_abs_d = sum_ext[OUT_BITS-1:0];
        if (ka_q) begin
          stg_kind_d  = KIND_KEEPALIVE;
          stg_delta_d = '0;
          stg_ch_d    = '0;
          stg_act_d   = '0;
          stg_val_d   = '0;
        end else begin
          stamp_d     = sum_stamp;
          residue_d   = RES_BITS'(rem_q[DIV_BITS-1:0]);
          stg_delta_d = OUT_BITS'(dvd_q[DeltaBits-1:0]);
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = stg_kind_q;
          out_data_d  = {stg_val_q, stg_act_q, stg_ch_q, stg_delta_q, stg_abs_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  // partial remainder stays below the divisor during division
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < {1'b0, div_w})
    else $error("partial remainder not below divisor");

  // division always starts from a cleared step counter
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && state_d == ST_DIV |=> cnt_q == '0)
    else $error("division started with stale step counter");

  // a keep-alive leaves the residue untouched
  a_ka_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_FIN) && ka_q |=> $stable(residue_q))
    else $error("keep-alive changed the residue");

  // a staged result reaches the output register once it is free
  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && out_free |=> m_axis_tvalid && state_q == ST_IDLE)
    else $error("staged result not loaded");

endmodule
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sample-to-timestamp event stamper. A scoreboard
// class tracks residue, absolute stamp and quiet count, works out the event
// due for each accepted request and compares it field by field with the
// output stream. Directed requests come first, then a longer quiet stretch
// ending in a keep-alive, then random call sequences under several register
// settings with idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import stes_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int MAX_REPORTS   = 40;
  localparam int PHASE_ITEMS   = 120;

  // one output event, fields as they appear on the output stream
  typedef struct packed {
    logic        kind;
    logic [31:0] abs_stamp;
    logic [31:0] delta;
    logic [15:0] channel;
    logic [7:0]  action;
    logic [15:0] value;
  } stamp_event_t;

  // stamper state mirror and queue of events still due
  class stamp_scoreboard;
    logic [15:0]  spu;
    logic [15:0]  kal;
    logic [31:0]  total;
    logic [31:0]  residue;
    logic [15:0]  quiet;
    stamp_event_t expected_events[$];
    int           errors;
    int           n_actions;
    int           n_keepalives;

    function new();
      spu          = SPU_RESET;
      kal          = KAL_RESET;
      total        = '0;
      residue      = '0;
      quiet        = '0;
      errors       = 0;
      n_actions    = 0;
      n_keepalives = 0;
    endfunction

    function void write_reg(logic addr, logic [15:0] val);
      if (addr == CFG_SPU) begin
        spu = val;
      end else begin
        kal = val;
      end
    endfunction

    // advance the mirror by one accepted request and queue its event, if any
    function void note_request(req_e rq, logic [15:0] el, logic [15:0] ch,
                               logic [7:0] ac, logic [15:0] va);
      logic [31:0]  divisor;
      logic [31:0]  quot;
      stamp_event_t ev;
      divisor = (spu == 16'd0) ? 32'd1 : {16'd0, spu};
      ev = '0;
      case (rq)
        REQ_FIRST: begin
          residue = residue + {16'd0, el};
          quot    = residue / divisor;
          residue = residue - quot * divisor;
          total   = total + quot;
          quiet   = '0;
          ev.kind      = KIND_ACTION;
          ev.abs_stamp = total;
          ev.delta     = quot;
          ev.channel   = ch;
          ev.action    = ac;
          ev.value     = va;
          expected_events.push_back(ev);
        end
        REQ_FURTHER: begin
          quiet = '0;
          ev.kind      = KIND_ACTION;
          ev.abs_stamp = total;
          ev.channel   = ch;
          ev.action    = ac;
          ev.value     = va;
          expected_events.push_back(ev);
        end
        REQ_TICK: begin
          residue = residue + {16'd0, el};
          quiet   = quiet + 16'd1;
          if (quiet == kal) begin
            quiet        = '0;
            ev.kind      = KIND_KEEPALIVE;
            ev.abs_stamp = total + residue / divisor;
            expected_events.push_back(ev);
          end
        end
        default: begin
          // unused request kind leaves everything as it was
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
      end
    endfunction

    // compare one output transfer with the oldest event due
    function void check_event(logic kind, logic [103:0] data);
      stamp_event_t got;
      stamp_event_t want;
      got.kind      = kind;
      got.abs_stamp = data[31:0];
      got.delta     = data[63:32];
      got.channel   = data[79:64];
      got.action    = data[87:80];
      got.value     = data[103:88];
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected event, expected none, got %h", $time, got);
        end
        return;
      end
      want = expected_events.pop_front();
      if (want.kind == KIND_KEEPALIVE) begin
        n_keepalives++;
      end else begin
        n_actions++;
      end
      compare_field("out_kind", {31'd0, want.kind}, {31'd0, got.kind});
      compare_field("absolute_stamp", want.abs_stamp, got.abs_stamp);
      compare_field("delta_stamp", want.delta, got.delta);
      compare_field("out_channel", {16'd0, want.channel}, {16'd0, got.channel});
      compare_field("out_action", {24'd0, want.action}, {24'd0, got.action});
      compare_field("out_value", {16'd0, want.value}, {16'd0, got.value});
    endfunction
  endclass

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          cfg_we_i      = 1'b0;
  logic          cfg_addr_i    = 1'b0;
  logic [15:0]   cfg_data_i    = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [55:0]   s_axis_tdata  = '0;
  logic [1:0]    s_axis_tuser  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [103:0]  m_axis_tdata;
  logic          m_axis_tuser;

  stamp_scoreboard stamps;
  int            src_idle_pct  = 0;
  int            sink_idle_pct = 0;
  int            hold_left     = 0;
  bit            hold_request  = 1'b0;
  int            n_requests    = 0;
  int            n_cfg_writes  = 0;

  sample_to_timestamp_event_stamper_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output side: check each transfer, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      stamps.check_event(m_axis_tuser, m_axis_tdata);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // run limit
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // field values with the extremes well represented
  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick8();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one request and wait for its transfer; valid stays high afterwards
  task automatic send_request(input req_e rq, input logic [15:0] el,
                              input logic [15:0] ch, input logic [7:0] ac,
                              input logic [15:0] va);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {va, ac, ch, el};
    s_axis_tuser  <= rq;
    do @(posedge clk_i); while (!s_axis_tready);
    stamps.note_request(rq, el, ch, ac, va);
    n_requests++;
  endtask

  // stop offering, wait for every due event, then let the divider finish
  task automatic settle();
    int waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (stamps.expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (stamps.expected_events.size() != 0) begin
      stamps.errors++;
      $display("%0t: %0d expected events never arrived, expected %h, got none",
               $time, stamps.expected_events.size(), stamps.expected_events[0]);
      stamps.expected_events.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic addr, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    stamps.write_reg(addr, val);
    n_cfg_writes++;
  endtask

  // random calls, quiet ticks, stray further actions and unused kinds
  task automatic run_random(input int n);
    int sent;
    int k;
    int len;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(99);
      if (k < 55) begin
        // well-formed call: first action then up to three further actions
        send_request(REQ_FIRST, pick16(), pick16(), pick8(), pick16());
        len = $urandom_range(3);
        repeat (len) send_request(REQ_FURTHER, pick16(), pick16(), pick8(), pick16());
        sent += len + 1;
      end else if (k < 85) begin
        // run of quiet ticks
        len = $urandom_range(1, 6);
        repeat (len) send_request(REQ_TICK, pick16(), pick16(), pick8(), pick16());
        sent += len;
      end else if (k < 93) begin
        // further action with no call open
        send_request(REQ_FURTHER, pick16(), pick16(), pick8(), pick16());
        sent++;
      end else begin
        send_request(REQ_UNUSED, pick16(), pick16(), pick8(), pick16());
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] spu, input logic [15:0] kal,
                           input int src_pct, input int sink_pct, input bit hold);
    settle();
    write_cfg(CFG_SPU, spu);
    write_cfg(CFG_KAL, kal);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    if (hold) begin
      hold_request = 1'b1;
    end
    run_random(PHASE_ITEMS);
  endtask

  // stimulus
  initial begin
    stamps = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, register reset values
    send_request(REQ_FURTHER, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(REQ_FIRST, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    send_request(REQ_FIRST, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(REQ_FURTHER, 16'h1234, 16'hA5A5, 8'h5A, 16'h0F0F);
    send_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(REQ_TICK, 16'hFFFF, 16'h0000, 8'h00, 16'h0000);
    send_request(REQ_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(REQ_FIRST, 16'd3, 16'd1, 8'd2, 16'd3);

    // zero divisor, keep-alive on every tick
    settle();
    write_cfg(CFG_SPU, 16'd0);
    write_cfg(CFG_KAL, 16'd1);
    send_request(REQ_TICK, 16'd7, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(REQ_FIRST, 16'd9, 16'd10, 8'd11, 16'd12);
    send_request(REQ_FURTHER, 16'd0, 16'hFFFF, 8'h80, 16'h8000);
    send_request(REQ_TICK, 16'd0, 16'd0, 8'd0, 16'd0);

    // largest divisor, keep-alive every second tick
    settle();
    write_cfg(CFG_SPU, 16'hFFFF);
    write_cfg(CFG_KAL, 16'd2);
    send_request(REQ_TICK, 16'hFFFF, 16'd0, 8'd0, 16'd0);
    send_request(REQ_TICK, 16'hFFFF, 16'd0, 8'd0, 16'd0);
    send_request(REQ_FIRST, 16'hFFFF, 16'h8001, 8'h81, 16'h8001);
    send_request(REQ_FURTHER, 16'hFFFF, 16'h7FFE, 8'h7E, 16'h7FFE);
    send_request(REQ_TICK, 16'd1, 16'd0, 8'd0, 16'd0);
    send_request(REQ_TICK, 16'd1, 16'd0, 8'd0, 16'd0);

    // longer quiet stretch up to a keep-alive; the next call stamps a large delta
    settle();
    write_cfg(CFG_SPU, 16'd1);
    write_cfg(CFG_KAL, 16'd48);
    send_request(REQ_FIRST, 16'd0, 16'd0, 8'd0, 16'd0);
    repeat (48) send_request(REQ_TICK, 16'hFFFF, pick16(), pick8(), pick16());
    send_request(REQ_FIRST, 16'd5, 16'hFFFF, 8'hFF, 16'hFFFF);

    // random phases under changing settings and idling
    run_phase(16'd1, 16'd3, 31, 63, 1'b0);
    run_phase(16'($urandom_range(2, 50)), 16'($urandom_range(1, 6)), 31, 63, 1'b0);
    run_phase(16'hFFFF, 16'd2, 63, 31, 1'b0);
    run_phase(16'($urandom), 16'd1, 63, 31, 1'b0);
    run_phase(16'd7, 16'd4, 0, 0, 1'b1);
    run_phase(16'd0, 16'($urandom_range(1, 6)), 0, 0, 1'b0);
    settle();

    $display("covered %0d requests giving %0d stamped actions and %0d keep-alives",
             n_requests, stamps.n_actions, stamps.n_keepalives);
    $display("%0d register writes, idling on both sides and one long output hold-off",
             n_cfg_writes);
    if (stamps.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sample_to_timestamp_event_stamper_unit.f]
rtl/stes_pkg.sv
rtl/sample_to_timestamp_event_stamper_unit.sv
bench/testbench.sv
